// ===== rtl/cpb_pkg.sv =====
// ----------------------------------------------------------------------------
// cpb_pkg: shared types and constants of the column post blitter
// Result kinds, opcodes, default screen geometry and the queue entry that
// travels from the parser to the address stage.
// ----------------------------------------------------------------------------
package cpb_pkg;

	localparam int DEF_SCREEN_WIDTH  = 320;
	localparam int DEF_SCREEN_HEIGHT = 200;
	localparam int DEF_SCREEN_COUNT  = 5;

	// Bit width of a row or column coordinate (values 0 to 1023).
	localparam int MAX_DIM_W = 10;

	localparam logic       OP_BEGIN = 1'b0;
	localparam logic       OP_BYTE  = 1'b1;
	localparam logic [7:0] END_MARK = 8'hff;

	typedef enum logic [2:0] {
		KIND_NONE    = 3'd0,
		KIND_PIXEL   = 3'd1,
		KIND_REJECT  = 3'd2,
		KIND_COL_END = 3'd3,
		KIND_DONE    = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [2:0]           screen;
		logic [MAX_DIM_W-1:0] row;
		logic [MAX_DIM_W-1:0] col;
		logic [7:0]           pixel;
	} cmd_t;

endpackage

// ===== rtl/cpb_if.sv =====
// ----------------------------------------------------------------------------
// cpb_if: request and result channels of the column post blitter
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface cpb_in_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [7:0]         data_byte;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [2:0]         target_screen;
	logic signed [15:0] left_offset;
	logic signed [15:0] top_offset;
	logic [9:0]         pic_width;
	logic [9:0]         pic_height;

	modport source (
		output valid, opcode, data_byte, pos_x, pos_y, target_screen,
		output left_offset, top_offset, pic_width, pic_height,
		input  ready
	);
	modport sink (
		input  valid, opcode, data_byte, pos_x, pos_y, target_screen,
		input  left_offset, top_offset, pic_width, pic_height,
		output ready
	);
endinterface

interface cpb_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [2:0]  dest_screen;
	logic [15:0] dest_offset;
	logic [7:0]  pixel_value;

	modport source (
		output valid, kind, dest_screen, dest_offset, pixel_value,
		input  ready
	);
	modport sink (
		input  valid, kind, dest_screen, dest_offset, pixel_value,
		output ready
	);
endinterface

// ===== rtl/cpb_front.sv =====
// ----------------------------------------------------------------------------
// cpb_front: request parser
// Checks picture headers, walks the post stream and emits one command per
// accepted request into the queue.
// ----------------------------------------------------------------------------
module cpb_front #(
	parameter int SCREEN_WIDTH  = cpb_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = cpb_pkg::DEF_SCREEN_HEIGHT,
	parameter int SCREEN_COUNT  = cpb_pkg::DEF_SCREEN_COUNT
) (
	input  logic          clk,
	input  logic          arst_n,
	cpb_in_if.sink        req,
	input  logic          q_full,
	output logic          q_push,
	output cpb_pkg::cmd_t q_cmd
);
	import cpb_pkg::*;

	localparam int XW  = $clog2(SCREEN_WIDTH + 1);
	localparam int YW  = $clog2(SCREEN_HEIGHT + 1);
	localparam int RW  = ((YW > 9) ? YW : 9) + 1;
	localparam int CSW = ((XW > 10) ? XW : 10) + 1;
	localparam logic signed [17:0] SW_S = 18'(SCREEN_WIDTH);
	localparam logic signed [17:0] SH_S = 18'(SCREEN_HEIGHT);

	typedef enum logic [2:0] {
		PH_IDLE, PH_TOP, PH_LEN, PH_PAD1, PH_PIX, PH_PAD2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [XW-1:0] base_x_q, base_x_d;
	logic [YW-1:0] base_y_q, base_y_d;
	logic [2:0]  screen_q, screen_d;
	logic [9:0]  col_idx_q, col_idx_d;
	logic [9:0]  col_total_q, col_total_d;
	logic [8:0]  post_row_q, post_row_d;
	logic [7:0]  left_q, left_d;

	logic signed [16:0] hx, hy;
	logic signed [17:0] hx_end, hy_end;
	logic               reject;
	logic [9:0]         col_inc;
	logic [7:0]         left_dec;
	logic [RW-1:0]      row_sum;
	logic [CSW-1:0]     col_sum;
	logic               accept;

	assign req.ready = !q_full;
	assign accept    = req.valid && !q_full;
	assign q_push    = accept;

	assign hx     = $signed({req.pos_x[15], req.pos_x}) -
	                $signed({req.left_offset[15], req.left_offset});
	assign hy     = $signed({req.pos_y[15], req.pos_y}) -
	                $signed({req.top_offset[15], req.top_offset});
	assign hx_end = $signed({hx[16], hx}) + $signed({8'd0, req.pic_width});
	assign hy_end = $signed({hy[16], hy}) + $signed({8'd0, req.pic_height});
	assign reject = hx[16] || hy[16] || (hx_end > SW_S) || (hy_end > SH_S) ||
	                ({1'b0, req.target_screen} >= 4'(SCREEN_COUNT));

	assign col_inc  = col_idx_q + 10'd1;
	assign left_dec = left_q - 8'd1;
	assign row_sum  = RW'(base_y_q) + RW'(post_row_q);
	assign col_sum  = CSW'(base_x_q) + CSW'(col_idx_q);

	always_comb begin
		phase_d     = phase_q;
		base_x_d    = base_x_q;
		base_y_d    = base_y_q;
		screen_d    = screen_q;
		col_idx_d   = col_idx_q;
		col_total_d = col_total_q;
		post_row_d  = post_row_q;
		left_d      = left_q;
		q_cmd       = '{kind: KIND_NONE, screen: '0, row: '0, col: '0, pixel: '0};
		if (req.opcode == OP_BEGIN) begin
			phase_d = PH_IDLE;
			if (reject) begin
				q_cmd.kind = KIND_REJECT;
			end else begin
				base_x_d    = hx[XW-1:0];
				base_y_d    = hy[YW-1:0];
				screen_d    = req.target_screen;
				col_idx_d   = '0;
				col_total_d = req.pic_width;
				post_row_d  = '0;
				left_d      = '0;
				if (req.pic_width == '0) begin
					q_cmd.kind = KIND_DONE;
				end else begin
					phase_d = PH_TOP;
				end
			end
		end else begin
			case (phase_q)
				PH_TOP: begin
					if (req.data_byte == END_MARK) begin
						col_idx_d = col_inc;
						if (col_inc >= col_total_q) begin
							phase_d    = PH_IDLE;
							q_cmd.kind = KIND_DONE;
						end else begin
							q_cmd.kind = KIND_COL_END;
						end
					end else begin
						post_row_d = {1'b0, req.data_byte};
						phase_d    = PH_LEN;
					end
				end
				PH_LEN: begin
					left_d  = req.data_byte;
					phase_d = PH_PAD1;
				end
				PH_PAD1: begin
					phase_d = (left_q == '0) ? PH_PAD2 : PH_PIX;
				end
				PH_PIX: begin
					post_row_d = post_row_q + 9'd1;
					left_d     = left_dec;
					if (left_dec == '0) begin
						phase_d = PH_PAD2;
					end
					if (row_sum < RW'(SCREEN_HEIGHT)) begin
						q_cmd.kind   = KIND_PIXEL;
						q_cmd.screen = screen_q;
						q_cmd.row    = MAX_DIM_W'(row_sum);
						q_cmd.col    = MAX_DIM_W'(col_sum);
						q_cmd.pixel  = req.data_byte;
					end
				end
				PH_PAD2: phase_d = PH_TOP;
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			base_x_q    <= '0;
			base_y_q    <= '0;
			screen_q    <= '0;
			col_idx_q   <= '0;
			col_total_q <= '0;
			post_row_q  <= '0;
			left_q      <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			base_x_q    <= base_x_d;
			base_y_q    <= base_y_d;
			screen_q    <= screen_d;
			col_idx_q   <= col_idx_d;
			col_total_q <= col_total_d;
			post_row_q  <= post_row_d;
			left_q      <= left_d;
		end
	end

endmodule

// ===== rtl/cpb_queue.sv =====
// ----------------------------------------------------------------------------
// cpb_queue: two-entry command queue
// Decouples the parser from the address stage.
// ----------------------------------------------------------------------------
module cpb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cpb_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output cpb_pkg::cmd_t head
);
	import cpb_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== rtl/cpb_back.sv =====
// ----------------------------------------------------------------------------
// cpb_back: address stage and result register
// Forms row * screen width + column and holds the result until taken.
// ----------------------------------------------------------------------------
module cpb_back #(
	parameter int SCREEN_WIDTH = cpb_pkg::DEF_SCREEN_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_not_empty,
	input  cpb_pkg::cmd_t q_head,
	output logic          q_pop,
	cpb_out_if.source     rsp
);
	import cpb_pkg::*;

	localparam int AW = 2 * MAX_DIM_W + 1;

	logic [AW-1:0] addr;
	logic          valid_q;
	logic [2:0]    kind_q;
	logic [2:0]    screen_q;
	logic [15:0]   offset_q;
	logic [7:0]    pixel_q;

	assign q_pop = q_not_empty && (!valid_q || rsp.ready);
	assign addr  = AW'(q_head.row) * AW'(SCREEN_WIDTH) + AW'(q_head.col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || rsp.ready) begin
			valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q   <= q_head.kind;
			screen_q <= q_head.screen;
			offset_q <= addr[15:0];
			pixel_q  <= q_head.pixel;
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.kind        = kind_q;
	assign rsp.dest_screen = screen_q;
	assign rsp.dest_offset = offset_q;
	assign rsp.pixel_value = pixel_q;

endmodule

// ===== rtl/column_post_patch_blitter_unit.sv =====
// ----------------------------------------------------------------------------
// column_post_patch_blitter_unit: column post picture blitter
// Turns a begin request and a stream of column post bytes into pixel writes.
// ----------------------------------------------------------------------------
// Channels: "item" takes requests (opcode 0 = picture header, 1 = one byte of
// the column post stream); "result" gives exactly one result per request:
// nothing, pixel write (screen, row * SCREEN_WIDTH + column, palette index),
// picture rejected, column ended or picture done.
// Throughput: one request per cycle, sustained, as long as results are taken.
// Path: the parser resolves the request and writes the queue at the accepting
// edge; the address stage does the constant multiply-add on the way into the
// result register, which holds the result until it is taken.
// Stall: a two-entry queue sits between parser and address stage; with the
// result held, the queue fills and item.ready drops after at most two more requests.
// Reset: arst_n clears the parser to idle (no picture active) and empties
// queue and result register; bytes received while idle give "nothing".
// ----------------------------------------------------------------------------
module column_post_patch_blitter_unit #(
	parameter int SCREEN_WIDTH  = cpb_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = cpb_pkg::DEF_SCREEN_HEIGHT,
	parameter int SCREEN_COUNT  = cpb_pkg::DEF_SCREEN_COUNT
) (
	input  logic      clk,
	input  logic      arst_n,
	cpb_in_if.sink    item,
	cpb_out_if.source result
);
	import cpb_pkg::*;

	// Parser to queue
	logic q_push;
	cmd_t q_cmd;
	logic q_full;
	// Queue to address stage
	logic q_pop;
	logic q_not_empty;
	cmd_t q_head;

	// Classify each request and advance the post stream walk.
	cpb_front #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.SCREEN_COUNT (SCREEN_COUNT)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (item),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd (q_cmd)
	);

	// Hold commands while the receiver stalls.
	cpb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.head     (q_head)
	);

	// Form the screen address and drive the result channel.
	cpb_back #(
		.SCREEN_WIDTH(SCREEN_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(q_not_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.rsp        (result)
	);

endmodule

// ===== rtl/cpb_checker.sv =====
// ----------------------------------------------------------------------------
// cpb_checker: port-level checks of the column post blitter
// Watches requests and results and tracks how many results are owed.
// ----------------------------------------------------------------------------
module cpb_checker #(
	parameter int SCREEN_COUNT = cpb_pkg::DEF_SCREEN_COUNT
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  kind,
	input logic [2:0]  dest_screen,
	input logic [15:0] dest_offset,
	input logic [7:0]  pixel_value
);
	import cpb_pkg::*;

	logic       in_fire;
	logic       out_fire;
	logic [2:0] owed_q;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= '0;
		end else begin
			owed_q <= owed_q + 3'(in_fire) - 3'(out_fire);
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> owed_q != 3'd0)
		else $error("result without a pending request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		owed_q <= 3'd3)
		else $error("more requests in flight than storage allows");

	a_pixel_screen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_PIXEL |-> {1'b0, dest_screen} < 4'(SCREEN_COUNT))
		else $error("pixel write to a screen out of range");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_PIXEL
			|-> dest_screen == '0 && dest_offset == '0 && pixel_value == '0)
		else $error("non-pixel result carries write fields");

endmodule

bind column_post_patch_blitter_unit cpb_checker #(
	.SCREEN_COUNT(SCREEN_COUNT)
) u_cpb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item.valid),
	.in_ready   (item.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.kind       (result.kind),
	.dest_screen(result.dest_screen),
	.dest_offset(result.dest_offset),
	.pixel_value(result.pixel_value)
);
